// File: rtl/clnw_pkg.sv
// shared types, constants and helpers for the character lcd nibble writer
`default_nettype none

package clnw_pkg;

    localparam int WAIT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int STEP_W      = 4;
    localparam int CMD_IDX_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WAIT_W-1:0] POWER_UP_WAIT_RST    = 16'd45000;
    localparam logic [WAIT_W-1:0] SECOND_WAKE_WAIT_RST = 16'd5000;
    localparam logic [WAIT_W-1:0] THIRD_WAKE_WAIT_RST  = 16'd200;
    localparam logic [WAIT_W-1:0] CLEAR_HOME_WAIT_RST  = 16'd2000;
    localparam logic [WAIT_W-1:0] WAIT_MAX             = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CLEAR_HOME_LIMIT = 8'h04;
    localparam logic [NIB_W-1:0]  WAKE_NIBBLE      = 4'h3;
    localparam logic [NIB_W-1:0]  FUNC_NIBBLE      = 4'h2;

    localparam logic [STEP_W-1:0] STEP_WAKE1      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_WAKE2      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WAKE3      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_FUNC4      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CMD_FIRST  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WRITE_LAST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 4'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER_UP_WAIT    = 2'd0,
        REG_SECOND_WAKE_WAIT = 2'd1,
        REG_THIRD_WAKE_WAIT  = 2'd2,
        REG_CLEAR_HOME_WAIT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [WAIT_W-1:0] power_up_wait;
        logic [WAIT_W-1:0] second_wake_wait;
        logic [WAIT_W-1:0] third_wake_wait;
        logic [WAIT_W-1:0] clear_home_wait;
    } cfg_t;

    typedef struct packed {
        logic              is_init;
        logic [BYTE_W-1:0] byte_value;
        logic              is_data;
        logic              clear_home;
    } entry_t;

    function automatic logic [BYTE_W-1:0] init_cmd(input logic [CMD_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] cmd;
        unique case (idx)
            3'd0:    cmd = 8'h28;
            3'd1:    cmd = 8'h08;
            3'd2:    cmd = 8'h01;
            3'd3:    cmd = 8'h0C;
            3'd4:    cmd = 8'h80;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

// File: rtl/char_lcd_nibble_writer_unit.sv
// top level of the character lcd nibble writer
//
// channel   dir  beat contents
// s_*       in   tdata: byte_value[7:0]; tuser: req_type, is_data
// m_*       out  tdata: nibble[3:0], wait_before_us[19:4], zero[23:20];
//                tuser: reg_select; tlast: last
// cfg_*     in   one 16-bit wait register per write
//
// one strobe beat per cycle from the sequencer while m_tready does not stall it: a write
// sends two strobes, an init fourteen; the step counter in the back part sets this
// front register and queue let requests arrive while strobes are still going out
// a stalled m_tready holds the output beat; input keeps flowing until the queue fills
// reset clears the queue, the pending wait and the waits to their defaults
`default_nettype none

module char_lcd_nibble_writer_unit #(
    parameter int QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [7:0]                        s_tdata,   // byte_value
    input  wire logic [1:0]                        s_tuser,   // req_type, is_data
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [23:0]                       m_tdata,   // nibble, wait_before_us
    output      logic                              m_tuser,   // reg_select
    output      logic                              m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [clnw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [clnw_pkg::WAIT_W-1:0]       cfg_wdata
);

    clnw_pkg::cfg_t   cfg;
    clnw_pkg::entry_t push_entry;
    clnw_pkg::entry_t head_entry;
    logic             push_valid;
    logic             push_ready;
    logic             head_valid;
    logic             pop;

    clnw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    clnw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    clnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/clnw_cfg.sv
// configuration registers for the wait times
`default_nettype none

module clnw_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [clnw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [clnw_pkg::WAIT_W-1:0]          cfg_wdata,
    output clnw_pkg::cfg_t                            cfg
);

    clnw_pkg::cfg_t cfg_reg;
    clnw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (clnw_pkg::cfg_idx_t'(cfg_index))
                clnw_pkg::REG_POWER_UP_WAIT:    cfg_next.power_up_wait    = cfg_wdata;
                clnw_pkg::REG_SECOND_WAKE_WAIT: cfg_next.second_wake_wait = cfg_wdata;
                clnw_pkg::REG_THIRD_WAKE_WAIT:  cfg_next.third_wake_wait  = cfg_wdata;
                clnw_pkg::REG_CLEAR_HOME_WAIT:  cfg_next.clear_home_wait  = cfg_wdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_wait    <= clnw_pkg::POWER_UP_WAIT_RST;
            cfg_reg.second_wake_wait <= clnw_pkg::SECOND_WAKE_WAIT_RST;
            cfg_reg.third_wake_wait  <= clnw_pkg::THIRD_WAKE_WAIT_RST;
            cfg_reg.clear_home_wait  <= clnw_pkg::CLEAR_HOME_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/clnw_front.sv
// input stage: takes request beats and classifies them for the queue
`default_nettype none

module clnw_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [clnw_pkg::BYTE_W-1:0]     s_tdata,
    input  wire logic [1:0]                      s_tuser,
    output      logic                            push_valid,
    input  wire logic                            push_ready,
    output clnw_pkg::entry_t                     push_entry
);

    logic             valid_reg;
    logic             valid_next;
    clnw_pkg::entry_t entry_reg;
    clnw_pkg::entry_t entry_next;

    assign s_tready = !valid_reg || push_ready;

    always_comb
    begin
        entry_next            = entry_reg;
        valid_next            = valid_reg;
        if (s_tready)
        begin
            valid_next            = s_tvalid;
            entry_next.is_init    = s_tuser[0];
            entry_next.is_data    = s_tuser[1];
            entry_next.byte_value = s_tdata;
            // clear display or cursor home instruction
            entry_next.clear_home = !s_tuser[0] && !s_tuser[1]
                                    && (s_tdata < clnw_pkg::CLEAR_HOME_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

`default_nettype wire

// File: rtl/clnw_queue.sv
// short request queue between the front and back parts
`default_nettype none

module clnw_queue #(
    parameter int DEPTH = clnw_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire clnw_pkg::entry_t push_entry,
    output      logic             head_valid,
    input  wire logic             pop,
    output clnw_pkg::entry_t      head_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    clnw_pkg::entry_t entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/clnw_back.sv
// strobe sequencer with pending wait and output register
`default_nettype none

module clnw_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire clnw_pkg::cfg_t                cfg,
    input  wire logic                          head_valid,
    input  wire clnw_pkg::entry_t              head_entry,
    output      logic                          pop,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [23:0]                   m_tdata,
    output      logic                          m_tuser,
    output      logic                          m_tlast
);

    logic [clnw_pkg::STEP_W-1:0]    step_reg;
    logic [clnw_pkg::STEP_W-1:0]    step_next;
    logic [clnw_pkg::WAIT_W-1:0]    pending_reg;
    logic [clnw_pkg::WAIT_W-1:0]    pending_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [clnw_pkg::NIB_W-1:0]     out_nib_reg;
    logic [clnw_pkg::NIB_W-1:0]     out_nib_next;
    logic [clnw_pkg::WAIT_W-1:0]    out_wait_reg;
    logic [clnw_pkg::WAIT_W-1:0]    out_wait_next;
    logic                           out_rs_reg;
    logic                           out_rs_next;
    logic                           out_last_reg;
    logic                           out_last_next;

    logic                           adv;
    logic                           fire;
    logic                           is_last;
    logic [clnw_pkg::WAIT_W:0]      first_sum;
    logic [clnw_pkg::WAIT_W-1:0]    first_wait;
    logic [clnw_pkg::STEP_W-1:0]    cmd_step;
    logic [clnw_pkg::BYTE_W-1:0]    cmd;
    logic [clnw_pkg::NIB_W-1:0]     nib;
    logic [clnw_pkg::WAIT_W-1:0]    wait_us;
    logic                           rs;
    logic [clnw_pkg::WAIT_W-1:0]    pend_upd;

    assign adv     = !out_valid_reg || m_tready;
    assign fire    = head_valid && adv;
    assign is_last = head_entry.is_init ? (step_reg == clnw_pkg::STEP_INIT_LAST)
                                        : (step_reg == clnw_pkg::STEP_WRITE_LAST);
    assign pop     = fire && is_last;

    assign first_sum  = {1'b0, cfg.power_up_wait} + {1'b0, pending_reg};
    assign first_wait = first_sum[clnw_pkg::WAIT_W] ? clnw_pkg::WAIT_MAX
                                                    : first_sum[clnw_pkg::WAIT_W-1:0];
    assign cmd_step   = step_reg - clnw_pkg::STEP_CMD_FIRST;
    assign cmd        = clnw_pkg::init_cmd(cmd_step[clnw_pkg::STEP_W-1:1]);

    always_comb
    begin
        nib      = '0;
        wait_us  = '0;
        rs       = 1'b0;
        pend_upd = pending_reg;
        if (!head_entry.is_init)
        begin
            rs = head_entry.is_data;
            if (step_reg == '0)
            begin
                nib     = head_entry.byte_value[7:4];
                wait_us = pending_reg;
            end
            else
            begin
                nib      = head_entry.byte_value[3:0];
                pend_upd = head_entry.clear_home ? cfg.clear_home_wait : '0;
            end
        end
        else
        begin
            priority if (step_reg == clnw_pkg::STEP_WAKE1)
            begin
                nib     = clnw_pkg::WAKE_NIBBLE;
                wait_us = first_wait;
            end
            else if (step_reg == clnw_pkg::STEP_WAKE2)
            begin
                nib     = clnw_pkg::WAKE_NIBBLE;
                wait_us = cfg.second_wake_wait;
            end
            else if (step_reg == clnw_pkg::STEP_WAKE3)
            begin
                nib     = clnw_pkg::WAKE_NIBBLE;
                wait_us = cfg.third_wake_wait;
            end
            else if (step_reg == clnw_pkg::STEP_FUNC4)
            begin
                nib      = clnw_pkg::FUNC_NIBBLE;
                pend_upd = '0;
            end
            else if (!cmd_step[0])
            begin
                nib     = cmd[7:4];
                wait_us = pending_reg;
            end
            else
            begin
                nib      = cmd[3:0];
                pend_upd = (cmd < clnw_pkg::CLEAR_HOME_LIMIT) ? cfg.clear_home_wait : '0;
            end
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        out_nib_next   = out_nib_reg;
        out_wait_next  = out_wait_reg;
        out_rs_next    = out_rs_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = head_valid;
        end
        if (fire)
        begin
            step_next     = is_last ? '0 : step_reg + 1'b1;
            pending_next  = pend_upd;
            out_nib_next  = nib;
            out_wait_next = wait_us;
            out_rs_next   = rs;
            out_last_next = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_nib_reg  <= out_nib_next;
        out_wait_reg <= out_wait_next;
        out_rs_reg   <= out_rs_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_wait_reg, out_nib_reg};
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/clnw_checker.sv
// port checker for the character lcd nibble writer, bound to the top level
`default_nettype none

module clnw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_last_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[19:4] == 16'h0000))
        else $error("final strobe carries a wait");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid straight out of reset");

endmodule

bind char_lcd_nibble_writer_unit clnw_checker u_clnw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
